FILE: rtl/elp_pkg.sv
// shared types and constants of the edge line parser
`timescale 1ns / 1ps
`default_nettype none

package elp_pkg;

   // character codes
   localparam logic [15:0] CHR_S       = 16'h0073;
   localparam logic [15:0] CHR_F       = 16'h0066;
   localparam logic [15:0] CHR_DASH    = 16'h002D;
   localparam logic [15:0] CHR_SPACE   = 16'h0020;
   localparam logic [15:0] CHR_NEWLINE = 16'h000A;
   localparam logic [15:0] CHR_ZERO    = 16'h0030;
   localparam logic [15:0] CHR_NINE    = 16'h0039;
   localparam logic [15:0] CHR_MAX     = 16'h00FF;

   // configuration registers
   localparam int unsigned CSR_INDEX_W    = 4;
   localparam int unsigned CSR_DATA_W     = 32;
   localparam int unsigned VCOUNT_W       = 20;
   localparam int unsigned TENS_W         = 29;
   localparam logic [CSR_INDEX_W-1:0] CSR_VERTEX_COUNT = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COST_TENS    = 4'd1;
   localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 20'd1024;
   localparam logic [TENS_W-1:0]   TENS_RESET   = 29'd6553;

   // result fields
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned VOUT_W   = 20;
   localparam int unsigned COUT_W   = 32;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_INPUT  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_VERTEX = 3'd2;
   localparam logic [STATUS_W-1:0] ST_COST   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_DASH   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_SPACE  = 3'd5;

   // symbol classes handed from the front to the back
   typedef enum logic [3:0] {
      TK_DIGIT   = 4'd0,
      TK_S       = 4'd1,
      TK_F       = 4'd2,
      TK_DASH    = 4'd3,
      TK_SPACE   = 4'd4,
      TK_NEWLINE = 4'd5,
      TK_OTHER   = 4'd6,
      TK_WIDE    = 4'd7,
      TK_END     = 4'd8
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type kind;
      logic [3:0]   digit;
   } token_type;

   typedef struct packed {
      logic      valid;
      token_type tok;
   } tok_chan_type;

endpackage

`default_nettype wire

FILE: rtl/edge_line_parser.sv
// top level of the edge line parser: configuration registers and front/queue/back
// Parses one text line "A-B C" followed by a newline, one character word per cycle, and
// gives one result word per line (status, both vertices and the cost). The block takes one
// word every cycle unless the queue is full: the front classifies each symbol and pushes
// it into a two-entry queue, and the back parser consumes one token per cycle into a
// result register unless a held result stalls it. rsp_valid rises once the back pops the
// token that ends the line, and the input keeps flowing while a result waits on rsp_stall
// until the queue fills. Configuration writes are always ready.
`timescale 1ns / 1ps
`default_nettype none

module edge_line_parser #(
   parameter int unsigned VERTEX_BITS = 20,
   parameter int unsigned COST_BITS   = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [15:0]                        req_symbol,
   input  wire logic                               req_end_marker,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [elp_pkg::STATUS_W-1:0]            rsp_status,
   output logic [elp_pkg::VOUT_W-1:0]              rsp_first_vertex,
   output logic [elp_pkg::VOUT_W-1:0]              rsp_second_vertex,
   output logic [elp_pkg::COUT_W-1:0]              rsp_edge_cost,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [elp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [elp_pkg::CSR_DATA_W-1:0]     csr_data
);

   logic [elp_pkg::VCOUNT_W-1:0] vcount_ff;
   logic [elp_pkg::TENS_W-1:0]   tens_ff;

   elp_pkg::tok_chan_type push;
   elp_pkg::tok_chan_type head;
   logic                  queue_full;
   logic                  pop;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= elp_pkg::VCOUNT_RESET;
         tens_ff   <= elp_pkg::TENS_RESET;
      end else if (csr_valid) begin
         if (csr_index == elp_pkg::CSR_VERTEX_COUNT) begin
            vcount_ff <= csr_data[elp_pkg::VCOUNT_W-1:0];
         end else if (csr_index == elp_pkg::CSR_COST_TENS) begin
            tens_ff <= csr_data[elp_pkg::TENS_W-1:0];
         end
      end
   end

   // symbol classifier
   elp_front u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_symbol     (req_symbol),
      .req_end_marker (req_end_marker),
      .queue_full     (queue_full),
      .push           (push)
   );

   // token queue
   elp_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   // parser and result register
   elp_back #(
      .VERTEX_BITS (VERTEX_BITS),
      .COST_BITS   (COST_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .pop               (pop),
      .vertex_count      (vcount_ff),
      .tens_bound        (tens_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_first_vertex  (rsp_first_vertex),
      .rsp_second_vertex (rsp_second_vertex),
      .rsp_edge_cost     (rsp_edge_cost)
   );

endmodule

`default_nettype wire

FILE: rtl/elp_front.sv
// front end: accepts words and classifies each symbol into a token
`timescale 1ns / 1ps
`default_nettype none

module elp_front (
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [15:0]          req_symbol,
   input  wire logic                 req_end_marker,
   input  wire logic                 queue_full,
   output elp_pkg::tok_chan_type     push
);

   elp_pkg::token_type tok;

   // symbol classification
   always_comb begin
      tok.digit = req_symbol[3:0];
      if (req_end_marker) begin
         tok.kind = elp_pkg::TK_END;
      end else if (req_symbol > elp_pkg::CHR_MAX) begin
         tok.kind = elp_pkg::TK_WIDE;
      end else if (req_symbol >= elp_pkg::CHR_ZERO && req_symbol <= elp_pkg::CHR_NINE) begin
         tok.kind = elp_pkg::TK_DIGIT;
      end else if (req_symbol == elp_pkg::CHR_S) begin
         tok.kind = elp_pkg::TK_S;
      end else if (req_symbol == elp_pkg::CHR_F) begin
         tok.kind = elp_pkg::TK_F;
      end else if (req_symbol == elp_pkg::CHR_DASH) begin
         tok.kind = elp_pkg::TK_DASH;
      end else if (req_symbol == elp_pkg::CHR_SPACE) begin
         tok.kind = elp_pkg::TK_SPACE;
      end else if (req_symbol == elp_pkg::CHR_NEWLINE) begin
         tok.kind = elp_pkg::TK_NEWLINE;
      end else begin
         tok.kind = elp_pkg::TK_OTHER;
      end
   end

   // handshake toward the queue
   assign req_stall  = queue_full;
   assign push.valid = req_valid & ~queue_full;
   assign push.tok   = tok;

endmodule

`default_nettype wire

FILE: rtl/elp_queue.sv
// two-entry token queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module elp_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire elp_pkg::tok_chan_type push,
   output logic                       full,
   output elp_pkg::tok_chan_type      head,
   input  wire logic                  pop
);

   elp_pkg::token_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head.valid = (count_ff != 2'd0);
   assign head.tok   = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push.valid && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push.valid && pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.tok;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/elp_back.sv
// back end: line parser state machine and result register
`timescale 1ns / 1ps
`default_nettype none

module elp_back #(
   parameter int unsigned VERTEX_BITS = 20,
   parameter int unsigned COST_BITS   = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire elp_pkg::tok_chan_type           head,
   output logic                                 pop,
   input  wire logic [elp_pkg::VCOUNT_W-1:0]    vertex_count,
   input  wire logic [elp_pkg::TENS_W-1:0]      tens_bound,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [elp_pkg::STATUS_W-1:0]         rsp_status,
   output logic [elp_pkg::VOUT_W-1:0]           rsp_first_vertex,
   output logic [elp_pkg::VOUT_W-1:0]           rsp_second_vertex,
   output logic [elp_pkg::COUT_W-1:0]           rsp_edge_cost
);

   localparam int unsigned VCMP = (VERTEX_BITS + 4 > elp_pkg::VCOUNT_W) ?
                                  VERTEX_BITS + 4 : elp_pkg::VCOUNT_W;
   localparam int unsigned CCMP = (COST_BITS > elp_pkg::TENS_W) ?
                                  COST_BITS : elp_pkg::TENS_W;

   typedef enum logic [7:0] {
      PH_FIRST    = 8'b0000_0001,
      PH_FIRST_S  = 8'b0000_0010,
      PH_FIRST_F  = 8'b0000_0100,
      PH_SECOND   = 8'b0000_1000,
      PH_SECOND_S = 8'b0001_0000,
      PH_SECOND_F = 8'b0010_0000,
      PH_COST     = 8'b0100_0000,
      PH_DONE     = 8'b1000_0000
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic                   seen_ff, seen_in;
   logic [VERTEX_BITS-1:0] first_ff, first_in;
   logic [VERTEX_BITS-1:0] second_ff, second_in;
   logic [COST_BITS-1:0]   cost_ff, cost_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [elp_pkg::STATUS_W-1:0]  status_ff;
   logic [elp_pkg::VOUT_W-1:0]    first_out_ff, second_out_ff;
   logic [elp_pkg::COUT_W-1:0]    cost_out_ff;

   logic                          out_free;
   logic                          emit;
   logic [elp_pkg::STATUS_W-1:0]  emit_status;
   elp_pkg::token_type            tok;

   logic [VERTEX_BITS-1:0] cur_vertex;
   logic [VCMP-1:0]        vertex_nv;
   logic                   vertex_fits;
   logic [VCMP-1:0]        vcount_ext;
   logic [VERTEX_BITS-1:0] vcount_val;
   logic [COST_BITS-1:0]   cost_nv;
   logic [CCMP-1:0]        cost_cmp;
   logic [CCMP-1:0]        tens_cmp;
   logic                   cost_fits;
   logic [31:0]            first_wide, second_wide, cost_wide;

   assign tok      = head.tok;
   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign pop      = head.valid & out_free;

   // shared vertex digit unit: acc * 10 + digit against the vertex count
   assign cur_vertex  = (phase_ff == PH_SECOND) ? second_ff : first_ff;
   assign vertex_nv   = (VCMP'(cur_vertex) << 3) + (VCMP'(cur_vertex) << 1) + VCMP'(tok.digit);
   assign vcount_ext  = VCMP'(vertex_count);
   assign vertex_fits = (vertex_nv < vcount_ext);
   assign vcount_val  = vcount_ext[VERTEX_BITS-1:0];

   // cost digit unit, wraps at the accumulator width
   assign cost_nv   = (cost_ff << 3) + (cost_ff << 1) + COST_BITS'(tok.digit);
   assign cost_cmp  = CCMP'(cost_ff);
   assign tens_cmp  = CCMP'(tens_bound);
   assign cost_fits = (cost_cmp < tens_cmp) || (cost_cmp == tens_cmp && tok.digit <= 4'd5);

   // parser next state
   always_comb begin
      phase_in    = phase_ff;
      seen_in     = seen_ff;
      first_in    = first_ff;
      second_in   = second_ff;
      cost_in     = cost_ff;
      emit        = 1'b0;
      emit_status = elp_pkg::ST_OK;
      if (pop) begin
         if (tok.kind == elp_pkg::TK_END) begin
            // end of string: report unless the line is already done, then restart
            unique case (phase_ff) inside
               PH_FIRST, PH_SECOND, PH_COST: begin
                  emit = 1'b1;
               end
               PH_FIRST_S, PH_FIRST_F: begin
                  emit        = 1'b1;
                  emit_status = elp_pkg::ST_DASH;
               end
               PH_SECOND_S, PH_SECOND_F: begin
                  emit        = 1'b1;
                  emit_status = elp_pkg::ST_SPACE;
               end
               PH_DONE: begin
                  emit = 1'b0;
               end
               default: begin
                  emit = 1'b0;
               end
            endcase
            phase_in  = PH_FIRST;
            seen_in   = 1'b0;
            first_in  = '0;
            second_in = '0;
            cost_in   = '0;
         end else begin
            unique case (phase_ff) inside
               PH_FIRST, PH_SECOND: begin
                  // vertex field
                  case (tok.kind) inside
                     elp_pkg::TK_WIDE: begin
                        emit        = 1'b1;
                        emit_status = elp_pkg::ST_INPUT;
                     end
                     elp_pkg::TK_DIGIT: begin
                        if (vertex_fits) begin
                           seen_in = 1'b1;
                           if (phase_ff == PH_FIRST) begin
                              first_in = vertex_nv[VERTEX_BITS-1:0];
                           end else begin
                              second_in = vertex_nv[VERTEX_BITS-1:0];
                           end
                        end else begin
                           emit        = 1'b1;
                           emit_status = elp_pkg::ST_VERTEX;
                        end
                     end
                     elp_pkg::TK_S, elp_pkg::TK_F: begin
                        if (!seen_ff) begin
                           if (phase_ff == PH_FIRST) begin
                              first_in = (tok.kind == elp_pkg::TK_S) ?
                                         VERTEX_BITS'(1) : vcount_val;
                              phase_in = (tok.kind == elp_pkg::TK_S) ? PH_FIRST_S : PH_FIRST_F;
                           end else begin
                              second_in = (tok.kind == elp_pkg::TK_S) ?
                                          VERTEX_BITS'(1) : vcount_val;
                              phase_in  = (tok.kind == elp_pkg::TK_S) ?
                                          PH_SECOND_S : PH_SECOND_F;
                           end
                        end else begin
                           emit        = 1'b1;
                           emit_status = (phase_ff == PH_FIRST) ?
                                         elp_pkg::ST_DASH : elp_pkg::ST_SPACE;
                        end
                     end
                     default: begin
                        // separator or separator error
                        if (phase_ff == PH_FIRST && tok.kind == elp_pkg::TK_DASH) begin
                           seen_in  = 1'b0;
                           phase_in = PH_SECOND;
                        end else if (phase_ff == PH_SECOND && tok.kind == elp_pkg::TK_SPACE) begin
                           seen_in  = 1'b0;
                           phase_in = PH_COST;
                        end else begin
                           emit        = 1'b1;
                           emit_status = (phase_ff == PH_FIRST) ?
                                         elp_pkg::ST_DASH : elp_pkg::ST_SPACE;
                        end
                     end
                  endcase
               end
               PH_FIRST_S, PH_FIRST_F: begin
                  // after a first-field shortcut
                  if (phase_ff == PH_FIRST_S && tok.kind == elp_pkg::TK_F) begin
                     first_in = vcount_val;
                     phase_in = PH_FIRST_F;
                  end else if (tok.kind == elp_pkg::TK_DASH) begin
                     seen_in  = 1'b0;
                     phase_in = PH_SECOND;
                  end else begin
                     emit        = 1'b1;
                     emit_status = elp_pkg::ST_DASH;
                  end
               end
               PH_SECOND_S, PH_SECOND_F: begin
                  // after a second-field shortcut
                  if (phase_ff == PH_SECOND_S && tok.kind == elp_pkg::TK_F) begin
                     second_in = vcount_val;
                     phase_in  = PH_SECOND_F;
                  end else if (tok.kind == elp_pkg::TK_SPACE) begin
                     phase_in = PH_COST;
                  end else begin
                     emit        = 1'b1;
                     emit_status = elp_pkg::ST_SPACE;
                  end
               end
               PH_COST: begin
                  // cost field
                  case (tok.kind)
                     elp_pkg::TK_DIGIT: begin
                        if (cost_fits) begin
                           cost_in = cost_nv;
                        end else begin
                           emit        = 1'b1;
                           emit_status = elp_pkg::ST_COST;
                        end
                     end
                     elp_pkg::TK_NEWLINE: begin
                        emit = 1'b1;
                     end
                     default: begin
                        emit        = 1'b1;
                        emit_status = elp_pkg::ST_INPUT;
                     end
                  endcase
               end
               PH_DONE: begin
                  // drop symbols until the end marker
                  emit = 1'b0;
               end
               default: begin
                  phase_in = PH_DONE;
               end
            endcase
            if (emit) begin
               phase_in = PH_DONE;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_FIRST;
         seen_ff   <= 1'b0;
         first_ff  <= '0;
         second_ff <= '0;
         cost_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         seen_ff   <= seen_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         cost_ff   <= cost_in;
      end
   end

   // result register
   assign first_wide  = 32'(first_ff);
   assign second_wide = 32'(second_ff);
   assign cost_wide   = 32'(cost_ff);

   always_comb begin
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (pop && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         status_ff     <= emit_status;
         first_out_ff  <= first_wide[elp_pkg::VOUT_W-1:0];
         second_out_ff <= second_wide[elp_pkg::VOUT_W-1:0];
         cost_out_ff   <= cost_wide[elp_pkg::COUT_W-1:0];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_first_vertex  = first_out_ff;
   assign rsp_second_vertex = second_out_ff;
   assign rsp_edge_cost     = cost_out_ff;

endmodule

`default_nettype wire
